### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same-cycle implication written on top of the plain check.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

### sv/cpms_pkg.sv
`timescale 1ns / 1ps

package cpms_pkg;

    localparam int PERIOD_W = 16;
    localparam int RATIO_W  = 12;
    localparam int ROT_W    = 28;
    localparam int LIN_W    = 25;

    // Divider datapath: divisor and remainder span period * 6 * ratio.
    localparam int REM_W = 31;
    localparam int NUM_W = 39;
    localparam int CNT_W = 5;

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1);

    localparam logic [29:0]      RATE_NUM  = 30'd1000000000;
    localparam logic [REM_W-1:0] RATE_REM  = REM_W'(RATE_NUM[29:28]);
    localparam logic [NUM_W-1:0] RATE_LOW  = {RATE_NUM[27:0], 11'd0};
    localparam logic [CNT_W-1:0] RATE_STEPS = CNT_W'(28);

    localparam logic [10:0]      LIN_NUM   = 11'd1413;
    localparam logic [REM_W-1:0] LIN_DEN   = REM_W'(10000);
    localparam logic [CNT_W-1:0] LIN_STEPS = CNT_W'(26);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV1,
        ST_LIN,
        ST_DIV2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [REM_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } t_div_req;

endpackage

### sv/cpms_if.sv
`timescale 1ns / 1ps

interface cpms_cap_if;
    import cpms_pkg::*;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] capture_stamp;
    modport source (output valid, output capture_stamp, input ready);
    modport sink   (input valid, input capture_stamp, output ready);
endinterface

interface cpms_cfg_if;
    import cpms_pkg::*;
    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] reduction_ratio;
    modport source (output valid, output reduction_ratio, input ready);
    modport sink   (input valid, input reduction_ratio, output ready);
endinterface

interface cpms_spd_if;
    import cpms_pkg::*;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_ticks;
    logic                speed_valid;
    logic [ROT_W-1:0]    rotation_milli_rps;
    logic [LIN_W-1:0]    linear_speed;
    modport source (output valid, output period_ticks, output speed_valid,
                    output rotation_milli_rps, output linear_speed, input ready);
    modport sink   (input valid, input period_ticks, input speed_valid,
                    input rotation_milli_rps, input linear_speed, output ready);
endinterface

### sv/cpms_sdiv.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cpms_sdiv
    import cpms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_busy,
    output logic [ROT_W-1:0] o_quo
);

    logic [REM_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_num, n_num;
    logic [REM_W-1:0] r_div, n_div;
    logic [ROT_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [REM_W:0]   w_trial;
    logic [REM_W:0]   w_diff;
    logic             w_ge;

    // Restoring division, one quotient bit per cycle; dividend bits enter MSB first.
    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = r_rem;
        n_num   = r_num;
        n_div   = r_div;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        if (i_req.start) begin
            n_rem = i_req.rem;
            n_num = i_req.num;
            n_div = i_req.divisor;
            n_quo = '0;
            n_cnt = i_req.steps;
        end else if (r_cnt != '0) begin
            n_rem = w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_quo = {r_quo[ROT_W-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

    `ASSERT_IMPL(a_start_idle, i_req.start, !o_busy, "divider started while busy")
    `ASSERT_IMPL(a_div_nonzero, o_busy, r_div != '0, "divider running with zero divisor")

endmodule

### sv/capture_period_to_motor_speed.sv
`timescale 1ns / 1ps

// Capture-period tachometer. Timer stamps arrive on i_cap and are taken in
// pairs: the first stamp of a pair is stored, the second forms the period
// (difference modulo 65536) and starts the speed calculation. One result per
// pair leaves on o_spd; the first stamp of a pair yields nothing.
// i_cfg writes the gearbox reduction ratio (a value of 0 acts as 1); it is
// always ready and should be written only while the block is idle.
// A first stamp is only stored. A second stamp keeps the block busy
// through one multiply, a 28-step serial division of 1e9 by
// period * 6 * ratio, a second multiply and a 26-step division by 10000,
// all on one bit-serial divider. A zero period goes straight to the output.
// Results sit in an output register; i_cap.ready stays high while a result
// waits there, but a finished calculation holds until that register is free,
// so a stalled receiver eventually stalls the capture channel.
// Reset clears the pair phase, sets the ratio to 1 and empties the output.
`include "assert_macros.svh"

module capture_period_to_motor_speed
    import cpms_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpms_cap_if.sink      i_cap,
    cpms_cfg_if.sink      i_cfg,
    cpms_spd_if.source    o_spd
);

    t_state               r_state, n_state;
    logic                 r_phase, n_phase;
    logic [PERIOD_W-1:0]  r_first, n_first;
    logic [PERIOD_W-1:0]  r_period, n_period;
    logic [RATIO_W-1:0]   r_ratio;
    logic [ROT_W-1:0]     r_rot, n_rot;
    logic [LIN_W-1:0]     r_lin, n_lin;
    logic                 r_sv, n_sv;
    logic                 r_o_valid, n_o_valid;
    logic [PERIOD_W-1:0]  r_o_period, n_o_period;
    logic                 r_o_sv, n_o_sv;
    logic [ROT_W-1:0]     r_o_rot, n_o_rot;
    logic [LIN_W-1:0]     r_o_lin, n_o_lin;

    t_div_req             w_req;
    logic                 w_div_busy;
    logic [ROT_W-1:0]     w_quo;
    logic                 w_cap_xfer;
    logic [PERIOD_W-1:0]  w_diff;
    logic [RATIO_W-1:0]   w_ratio;
    logic [PERIOD_W+2:0]  w_p6;
    logic [REM_W-1:0]     w_divisor;
    logic [NUM_W-1:0]     w_scaled;

    cpms_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    assign i_cap.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_cap_xfer  = i_cap.valid && i_cap.ready;
    assign w_diff      = i_cap.capture_stamp - r_first;
    assign w_ratio     = (r_ratio == '0) ? RATIO_RESET : r_ratio;
    assign w_p6        = {1'b0, r_period, 2'b00} + {2'b00, r_period, 1'b0};
    assign w_divisor   = REM_W'(w_p6) * REM_W'(w_ratio);
    assign w_scaled    = NUM_W'(r_rot) * NUM_W'(LIN_NUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Every 16-bit nonzero period passes the plausibility check, since
    // 1e7 / 65535 is still above 150; a nonzero period is therefore valid.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_first    = r_first;
        n_period   = r_period;
        n_rot      = r_rot;
        n_lin      = r_lin;
        n_sv       = r_sv;
        n_o_valid  = r_o_valid && !o_spd.ready;
        n_o_period = r_o_period;
        n_o_sv     = r_o_sv;
        n_o_rot    = r_o_rot;
        n_o_lin    = r_o_lin;
        w_req      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_cap_xfer) begin
                    if (!r_phase) begin
                        n_first = i_cap.capture_stamp;
                        n_phase = 1'b1;
                    end else begin
                        n_phase  = 1'b0;
                        n_period = w_diff;
                        n_rot    = '0;
                        n_lin    = '0;
                        n_sv     = 1'b0;
                        n_state  = (w_diff == '0) ? ST_DONE : ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                w_req.start   = 1'b1;
                w_req.rem     = RATE_REM;
                w_req.num     = RATE_LOW;
                w_req.divisor = w_divisor;
                w_req.steps   = RATE_STEPS;
                n_state       = ST_DIV1;
            end
            ST_DIV1: begin
                if (!w_div_busy) begin
                    n_rot   = w_quo;
                    n_state = ST_LIN;
                end
            end
            ST_LIN: begin
                // The top 13 bits of the product stay below 10000, so they seed the remainder.
                w_req.start   = 1'b1;
                w_req.rem     = REM_W'(w_scaled[NUM_W-1:26]);
                w_req.num     = {w_scaled[25:0], 13'd0};
                w_req.divisor = LIN_DEN;
                w_req.steps   = LIN_STEPS;
                n_state       = ST_DIV2;
            end
            ST_DIV2: begin
                if (!w_div_busy) begin
                    n_lin   = w_quo[LIN_W-1:0];
                    n_sv    = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || o_spd.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_period = r_period;
                    n_o_sv     = r_sv;
                    n_o_rot    = r_rot;
                    n_o_lin    = r_lin;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_first   <= '0;
            r_ratio   <= RATIO_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_first   <= n_first;
            r_o_valid <= n_o_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_ratio <= i_cfg.reduction_ratio;
            end
        end
        r_period   <= n_period;
        r_rot      <= n_rot;
        r_lin      <= n_lin;
        r_sv       <= n_sv;
        r_o_period <= n_o_period;
        r_o_sv     <= n_o_sv;
        r_o_rot    <= n_o_rot;
        r_o_lin    <= n_o_lin;
    end

    assign o_spd.valid              = r_o_valid;
    assign o_spd.period_ticks       = r_o_period;
    assign o_spd.speed_valid        = r_o_sv;
    assign o_spd.rotation_milli_rps = r_o_rot;
    assign o_spd.linear_speed       = r_o_lin;

    `ASSERT_IMPL(a_invalid_zero, o_spd.valid && !o_spd.speed_valid,
        (o_spd.rotation_milli_rps == '0) && (o_spd.linear_speed == '0),
        "invalid result carries nonzero speed")
    `ASSERT_IMPL(a_valid_period, o_spd.valid && o_spd.speed_valid,
        o_spd.period_ticks != '0, "speed reported for a zero period")
    `ASSERT_IMPL(a_cap_idle, w_cap_xfer, !w_div_busy,
        "capture transfer while the divider runs")
    `ASSERT_CLK(a_phase_flip, w_cap_xfer |=> (r_phase != $past(r_phase)),
        "pair phase did not advance on a capture transfer")

endmodule
